// ===== design/bfbp_pkg.sv =====
// shared types, widths and codes for the best-fit block pool
package bfbp_pkg;

  // default number of pool slots
  localparam int POOL_DEPTH_DEF = 16;

  // field widths
  localparam int LIMIT_W = 5;
  localparam int SIZE_W  = 24;
  localparam int ADDR_W  = 32;
  localparam int CMD_W   = 2;

  // pool limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // control part of the search token passed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

endpackage

// ===== design/bfbp_cell.sv =====
// one pool slot with its stage of the best-fit search chain
module bfbp_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  // broadcast slot write
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_idx,
  input  logic [bfbp_pkg::ADDR_W-1:0] wr_addr,
  input  logic [bfbp_pkg::SIZE_W-1:0] wr_size,
  // pool occupancy and requested size
  input  logic [CNT_W-1:0]           count,
  input  logic [bfbp_pkg::SIZE_W-1:0] req_size,
  // token from the previous cell
  input  bfbp_pkg::tok_ctl_t         in_ctl,
  input  logic [IDX_W-1:0]           in_idx,
  input  logic [bfbp_pkg::SIZE_W-1:0] in_size,
  input  logic [bfbp_pkg::ADDR_W-1:0] in_addr,
  input  logic [bfbp_pkg::ADDR_W-1:0] in_last_addr,
  input  logic [bfbp_pkg::SIZE_W-1:0] in_last_size,
  // token to the next cell
  output bfbp_pkg::tok_ctl_t         out_ctl,
  output logic [IDX_W-1:0]           out_idx,
  output logic [bfbp_pkg::SIZE_W-1:0] out_size,
  output logic [bfbp_pkg::ADDR_W-1:0] out_addr,
  output logic [bfbp_pkg::ADDR_W-1:0] out_last_addr,
  output logic [bfbp_pkg::SIZE_W-1:0] out_last_size
);

  logic [bfbp_pkg::ADDR_W-1:0] slot_addr;
  logic [bfbp_pkg::SIZE_W-1:0] slot_size;
  logic                        occupied;
  logic                        is_last;
  logic                        take;

  // slot storage, written by a free or by the move of the last entry
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
      slot_addr <= wr_addr;
      slot_size <= wr_size;
    end
  end

  // compare this slot with the best block seen so far
  always_comb begin
    occupied = CNT_W'(CELL_IDX) < count;
    is_last  = count == CNT_W'(CELL_IDX + 1);
    take     = occupied && (slot_size >= req_size) &&
               (!in_ctl.found || (slot_size < in_size));
  end

  // token control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
      out_ctl.found <= in_ctl.found | take;
    end
  end

  // token payload
  always_ff @(posedge clk) begin
    out_idx       <= take ? IDX_W'(CELL_IDX) : in_idx;
    out_size      <= take ? slot_size : in_size;
    out_addr      <= take ? slot_addr : in_addr;
    out_last_addr <= is_last ? slot_addr : in_last_addr;
    out_last_size <= is_last ? slot_size : in_last_size;
  end

endmodule

// ===== design/best_fit_block_pool.sv =====
// top level of the best-fit free block pool: control, result register and cell chain
//
// Holds up to POOL_DEPTH freed blocks (address and size). Requests come in on
// the s_ channel, one result per request goes out on the m_ channel.
// s_tuser carries the command: alloc, free or reset pool; s_tdata the request
// size, block address and block size. m_tdata returns address and size,
// m_tuser the hit and dropped flags. cfg_we/cfg_wdata set the pool limit.
// An alloc sends a search token down a chain of POOL_DEPTH cells, one cell a
// cycle; each cell holds one slot and keeps the smallest fitting block seen.
// An alloc result passes from the chain end through the pending result
// register to the output register; free, reset pool and unused commands go
// straight to those two registers. A new request is taken only in idle, once
// the previous result has been loaded into the output register.
// rst empties the pool and sets the limit to 16. While the receiver stalls
// the result stays in the output register; one further request can be
// taken and is held finished until the output register is free.
module best_fit_block_pool #(
  parameter int POOL_DEPTH = bfbp_pkg::POOL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,   // pool_limit
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,     // req_size[23:0], block_addr[55:24], block_size[79:56]
  input  logic [1:0]  s_tuser,     // cmd[1:0]
  // result channel
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [55:0] m_tdata,     // addr[31:0], real_size[55:32]
  output logic [1:0]  m_tuser      // hit[0], dropped[1]
);

  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W = (CNT_W > bfbp_pkg::LIMIT_W) ? CNT_W : bfbp_pkg::LIMIT_W;
  localparam int SW    = bfbp_pkg::SIZE_W;
  localparam int AW    = bfbp_pkg::ADDR_W;

  bfbp_pkg::state_t state;
  bfbp_pkg::state_t state_next;

  logic [bfbp_pkg::LIMIT_W-1:0] pool_limit;
  logic [CNT_W-1:0]             count;
  logic [SW-1:0]                req;
  logic [SW-1:0]                req_cur;
  logic                         pend_hit;
  logic                         pend_drop;
  logic [AW-1:0]                pend_addr;
  logic [SW-1:0]                pend_size;

  // request fields
  logic [bfbp_pkg::CMD_W-1:0] in_cmd;
  logic [SW-1:0]              in_req;
  logic [AW-1:0]              in_baddr;
  logic [SW-1:0]              in_bsize;

  logic             s_xfer;
  logic             out_load;
  logic             start;
  logic             scan_done;
  logic [CMP_W-1:0] lim_eff;
  logic             room;
  logic             free_ok;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [AW-1:0]    wr_addr;
  logic [SW-1:0]    wr_size;

  // chain links, index k feeds cell k
  bfbp_pkg::tok_ctl_t ch_ctl       [POOL_DEPTH+1];
  logic [IDX_W-1:0]   ch_idx       [POOL_DEPTH+1];
  logic [SW-1:0]      ch_size      [POOL_DEPTH+1];
  logic [AW-1:0]      ch_addr      [POOL_DEPTH+1];
  logic [AW-1:0]      ch_last_addr [POOL_DEPTH+1];
  logic [SW-1:0]      ch_last_size [POOL_DEPTH+1];

  assign in_cmd   = s_tuser;
  assign in_req   = s_tdata[23:0];
  assign in_baddr = s_tdata[55:24];
  assign in_bsize = s_tdata[79:56];

  // limit in force and room for a free
  always_comb begin
    if (CMP_W'(pool_limit) > CMP_W'(POOL_DEPTH)) begin
      lim_eff = CMP_W'(POOL_DEPTH);
    end else begin
      lim_eff = CMP_W'(pool_limit);
    end
    room    = CMP_W'(count) < lim_eff;
    free_ok = s_xfer && (in_cmd == bfbp_pkg::CMD_FREE) && room;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bfbp_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (in_cmd == bfbp_pkg::CMD_ALLOC) begin
            state_next = bfbp_pkg::ST_SCAN;
          end else begin
            state_next = bfbp_pkg::ST_DONE;
          end
        end
      end
      bfbp_pkg::ST_SCAN: begin
        if (ch_ctl[POOL_DEPTH].valid) begin
          state_next = bfbp_pkg::ST_DONE;
        end
      end
      bfbp_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = bfbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bfbp_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    out_load  = 1'b0;
    scan_done = 1'b0;
    case (state)
      bfbp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      bfbp_pkg::ST_SCAN: begin
        scan_done = ch_ctl[POOL_DEPTH].valid;
      end
      bfbp_pkg::ST_DONE: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign s_xfer = s_tvalid && s_tready;
  assign start  = s_xfer && (in_cmd == bfbp_pkg::CMD_ALLOC);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pool limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_limit <= bfbp_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      pool_limit <= cfg_wdata;
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s_xfer && (in_cmd == bfbp_pkg::CMD_RESET)) begin
      count <= '0;
    end else if (free_ok) begin
      count <= count + CNT_W'(1);
    end else if (scan_done && ch_ctl[POOL_DEPTH].found) begin
      count <= count - CNT_W'(1);
    end
  end

  // slot write: append on free, move last entry into the taken slot on a hit
  always_comb begin
    wr_en   = free_ok || (scan_done && ch_ctl[POOL_DEPTH].found);
    wr_idx  = count[IDX_W-1:0];
    wr_addr = in_baddr;
    wr_size = in_bsize;
    if (scan_done) begin
      wr_idx  = ch_idx[POOL_DEPTH];
      wr_addr = ch_last_addr[POOL_DEPTH];
      wr_size = ch_last_size[POOL_DEPTH];
    end
  end

  // request size held for the search
  always_ff @(posedge clk) begin
    if (start) begin
      req <= in_req;
    end
  end

  // size seen by the cells: the first cell compares in the transfer cycle itself
  assign req_cur = start ? in_req : req;

  // finished result waiting for the output register
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      pend_hit  <= 1'b0;
      pend_drop <= (in_cmd == bfbp_pkg::CMD_FREE) && !room;
      pend_addr <= '0;
      pend_size <= '0;
    end else if (scan_done) begin
      pend_hit  <= ch_ctl[POOL_DEPTH].found;
      pend_drop <= 1'b0;
      pend_addr <= ch_ctl[POOL_DEPTH].found ? ch_addr[POOL_DEPTH] : '0;
      pend_size <= ch_ctl[POOL_DEPTH].found ? ch_size[POOL_DEPTH] : req;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {pend_size, pend_addr};
      m_tuser <= {pend_drop, pend_hit};
    end
  end

  // token entering the chain
  assign ch_ctl[0]       = '{valid: start, found: 1'b0};
  assign ch_idx[0]       = '0;
  assign ch_size[0]      = '0;
  assign ch_addr[0]      = '0;
  assign ch_last_addr[0] = '0;
  assign ch_last_size[0] = '0;

  // row of slot cells
  for (genvar k = 0; k < POOL_DEPTH; k++) begin : g_cell
    bfbp_cell #(
      .CELL_IDX (k),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .wr_en         (wr_en),
      .wr_idx        (wr_idx),
      .wr_addr       (wr_addr),
      .wr_size       (wr_size),
      .count         (count),
      .req_size      (req_cur),
      .in_ctl        (ch_ctl[k]),
      .in_idx        (ch_idx[k]),
      .in_size       (ch_size[k]),
      .in_addr       (ch_addr[k]),
      .in_last_addr  (ch_last_addr[k]),
      .in_last_size  (ch_last_size[k]),
      .out_ctl       (ch_ctl[k+1]),
      .out_idx       (ch_idx[k+1]),
      .out_size      (ch_size[k+1]),
      .out_addr      (ch_addr[k+1]),
      .out_last_addr (ch_last_addr[k+1]),
      .out_last_size (ch_last_size[k+1])
    );
  end

  // occupancy never exceeds the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(POOL_DEPTH) >= count)
    else $error("pool occupancy above depth");

  // a block found by the search lies in an occupied slot
  a_found_in_pool: assert property (@(posedge clk) disable iff (rst)
    (ch_ctl[POOL_DEPTH].valid && ch_ctl[POOL_DEPTH].found) |->
    (CNT_W'(ch_idx[POOL_DEPTH]) < count))
    else $error("search result outside occupied slots");

  // a kept free grows the pool by one
  a_free_grows: assert property (@(posedge clk) disable iff (rst)
    free_ok |=> (count == $past(count) + CNT_W'(1)))
    else $error("kept free did not grow the pool");

  // search token only reaches the end while a search is running
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    ch_ctl[POOL_DEPTH].valid |-> (state == bfbp_pkg::ST_SCAN))
    else $error("search token outside scan");

  // a result is never both a hit and a dropped free
  a_hit_xor_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("hit and dropped both set");

endmodule

// ===== bench/tb_best_fit_block_pool.sv =====
// testbench for the best-fit block pool: directed and random requests checked against a predictor
module tb_best_fit_block_pool;

  typedef logic [bfbp_pkg::SIZE_W-1:0] size_t;

  // command code the block leaves unused
  localparam logic [bfbp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [bfbp_pkg::SIZE_W-1:0] SIZE_MAX = '1;
  localparam logic [bfbp_pkg::ADDR_W-1:0] ADDR_MAX = '1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = bfbp_pkg::POOL_DEPTH_DEF + 6;

  typedef struct packed {
    logic [bfbp_pkg::CMD_W-1:0]  cmd;
    logic [bfbp_pkg::SIZE_W-1:0] req_size;
    logic [bfbp_pkg::ADDR_W-1:0] block_addr;
    logic [bfbp_pkg::SIZE_W-1:0] block_size;
  } pool_req_t;

  typedef struct packed {
    logic                        hit;
    logic [bfbp_pkg::ADDR_W-1:0] addr;
    logic [bfbp_pkg::SIZE_W-1:0] real_size;
    logic                        dropped;
  } pool_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;     // req_size[23:0], block_addr[55:24], block_size[79:56]
  logic [1:0]  s_tuser;     // cmd[1:0]
  logic        m_tready;
  logic        m_tvalid;
  logic [55:0] m_tdata;     // addr[31:0], real_size[55:32]
  logic [1:0]  m_tuser;     // hit[0], dropped[1]

  // predictor copy of the pool
  logic [bfbp_pkg::ADDR_W-1:0]  pool_addr [bfbp_pkg::POOL_DEPTH_DEF];
  logic [bfbp_pkg::SIZE_W-1:0]  pool_size [bfbp_pkg::POOL_DEPTH_DEF];
  int                           pool_fill;
  logic [bfbp_pkg::LIMIT_W-1:0] limit_reg;

  pool_result_t pending_results[$];
  int           mismatch_count;
  int           cycle_count;
  int           stall_left;
  bit           calm;

  best_fit_block_pool dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // best-fit search, swap-with-last removal, append on free
  function automatic pool_result_t predict_pool_op(input pool_req_t rq);
    pool_result_t res;
    int best;
    int lim;
    res = '0;
    best = -1;
    lim = (limit_reg > bfbp_pkg::POOL_DEPTH_DEF) ? bfbp_pkg::POOL_DEPTH_DEF : int'(limit_reg);
    case (rq.cmd)
      bfbp_pkg::CMD_ALLOC: begin
        for (int i = 0; i < pool_fill; i++)
          if (pool_size[i] >= rq.req_size && (best < 0 || pool_size[i] < pool_size[best]))
            best = i;
        if (best >= 0) begin
          res.hit = 1'b1;
          res.addr = pool_addr[best];
          res.real_size = pool_size[best];
          pool_addr[best] = pool_addr[pool_fill-1];
          pool_size[best] = pool_size[pool_fill-1];
          pool_fill--;
        end else begin
          res.real_size = rq.req_size;
        end
      end
      bfbp_pkg::CMD_FREE: begin
        if (pool_fill < lim) begin
          pool_addr[pool_fill] = rq.block_addr;
          pool_size[pool_fill] = rq.block_size;
          pool_fill++;
        end else begin
          res.dropped = 1'b1;
        end
      end
      bfbp_pkg::CMD_RESET: pool_fill = 0;
      default: ;
    endcase
    return res;
  endfunction

  // result channel stalls at random in bursts, with no new bursts once calm is set
  always @(negedge clk) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 3);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    pool_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no prediction pending");
      end else begin
        exp_res = pending_results.pop_front();
        if (m_tuser[0] !== exp_res.hit)
          report_mismatch($sformatf("hit %b, expected %b", m_tuser[0], exp_res.hit));
        if (m_tuser[1] !== exp_res.dropped)
          report_mismatch($sformatf("dropped %b, expected %b", m_tuser[1], exp_res.dropped));
        if (m_tdata[31:0] !== exp_res.addr)
          report_mismatch($sformatf("addr %h, expected %h", m_tdata[31:0], exp_res.addr));
        if (m_tdata[55:32] !== exp_res.real_size)
          report_mismatch($sformatf("real_size %h, expected %h",
                                    m_tdata[55:32], exp_res.real_size));
      end
    end
  end

  // send one request, with an optional gap first; returns at the falling edge after the transfer
  task automatic send_req(input logic [bfbp_pkg::CMD_W-1:0] cmd,
                          input logic [bfbp_pkg::SIZE_W-1:0] req_size,
                          input logic [bfbp_pkg::ADDR_W-1:0] block_addr,
                          input logic [bfbp_pkg::SIZE_W-1:0] block_size);
    pool_req_t rq;
    rq = '{cmd: cmd, req_size: req_size, block_addr: block_addr, block_size: block_size};
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {block_size, block_addr, req_size};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_pool_op(rq));
    @(negedge clk);
  endtask

  task automatic send_alloc(input logic [bfbp_pkg::SIZE_W-1:0] req_size);
    send_req(bfbp_pkg::CMD_ALLOC, req_size, $urandom, size_t'($urandom));
  endtask

  task automatic send_free(input logic [bfbp_pkg::ADDR_W-1:0] block_addr,
                           input logic [bfbp_pkg::SIZE_W-1:0] block_size);
    send_req(bfbp_pkg::CMD_FREE, size_t'($urandom), block_addr, block_size);
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_pool_limit(input logic [bfbp_pkg::LIMIT_W-1:0] value);
    wait_results_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_reg = value;
  endtask

  // empty pool: misses at both size extremes, unused command, reset pool
  task automatic test_empty_pool();
    send_alloc('0);
    send_alloc(SIZE_MAX);
    send_req(CMD_UNUSED, SIZE_MAX, ADDR_MAX, SIZE_MAX);
    send_req(bfbp_pkg::CMD_RESET, SIZE_MAX, ADDR_MAX, SIZE_MAX);
    send_alloc(24'd1);
  endtask

  // smallest fit wins, ties to the lowest slot, last slot moves into the hole
  task automatic test_best_fit_order();
    send_free(32'h0000_0000, 24'd100);
    send_free(ADDR_MAX, 24'd50);
    send_free(32'h0000_1234, 24'd50);
    send_free(32'h0000_0005, SIZE_MAX);
    send_free(32'h0000_0006, 24'd0);
    send_alloc(24'd50);
    send_alloc(24'd50);
    send_alloc(24'd0);
    send_alloc(24'd101);
    send_alloc(SIZE_MAX);
    send_alloc(24'd100);
    send_alloc(24'd0);
    // reset pool throws away what is held
    send_free(32'hA5A5_5A5A, 24'd7);
    send_free(32'h5A5A_A5A5, 24'd8);
    send_req(bfbp_pkg::CMD_RESET, '0, '0, '0);
    send_alloc(24'd0);
  endtask

  // zero limit, limit of one, limit lowered below the fill
  task automatic test_limit_settings();
    set_pool_limit(5'd0);
    send_free(32'h1111_1111, 24'd10);
    send_alloc(24'd0);
    set_pool_limit(5'd1);
    send_free(32'h2222_2222, 24'd20);
    send_free(32'h3333_3333, 24'd30);
    send_alloc(24'd5);
    set_pool_limit(5'd16);
    send_free(32'h4444_0001, 24'd40);
    send_free(32'h4444_0002, 24'd41);
    send_free(32'h4444_0003, 24'd42);
    set_pool_limit(5'd2);
    send_free(32'h4444_0004, 24'd43);
    send_alloc(24'd41);
    send_free(32'h4444_0005, 24'd44);
    send_alloc(24'd0);
    send_free(32'h4444_0006, 24'd45);
    send_alloc(24'd0);
    send_alloc(24'd0);
  endtask

  function automatic logic [bfbp_pkg::SIZE_W-1:0] pick_block_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return size_t'($urandom_range(0, 31));
    if (sel < 65 && pool_fill > 0) return pool_size[$urandom_range(0, pool_fill - 1)];
    if (sel < 72) return ($urandom_range(0, 1) != 0) ? SIZE_MAX : '0;
    return size_t'($urandom);
  endfunction

  function automatic logic [bfbp_pkg::SIZE_W-1:0] pick_req_size();
    logic [bfbp_pkg::SIZE_W-1:0] s;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50 && pool_fill > 0) begin
      s = pool_size[$urandom_range(0, pool_fill - 1)];
      case ($urandom_range(0, 3))
        0: if (s != '0) s = s - 1'b1;
        1: if (s != SIZE_MAX) s = s + 1'b1;
        default: ;
      endcase
      return s;
    end
    if (sel < 75) return size_t'($urandom_range(0, 40));
    if (sel < 85) return ($urandom_range(0, 1) != 0) ? SIZE_MAX : '0;
    return size_t'($urandom);
  endfunction

  // random mix of frees and allocs with the odd reset pool and unused command
  task automatic test_random_traffic(input logic [bfbp_pkg::LIMIT_W-1:0] limit,
                                     input int count, input int free_pct);
    int sel;
    int lim;
    logic [bfbp_pkg::ADDR_W-1:0] a;
    set_pool_limit(limit);
    lim = (limit > bfbp_pkg::POOL_DEPTH_DEF) ? bfbp_pkg::POOL_DEPTH_DEF : int'(limit);
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      a = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? ADDR_MAX : '0) : $urandom;
      if (sel < 2)
        send_req(bfbp_pkg::CMD_RESET, size_t'($urandom), $urandom, size_t'($urandom));
      else if (sel < 4)
        send_req(CMD_UNUSED, size_t'($urandom), $urandom, size_t'($urandom));
      else if (sel < 4 + ((pool_fill < lim) ? free_pct : free_pct / 2))
        send_free(a, pick_block_size());
      else
        send_alloc(pick_req_size());
    end
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    calm = 1'b0;
    pool_fill = 0;
    limit_reg = bfbp_pkg::LIMIT_RESET;
    foreach (pool_addr[i]) begin
      pool_addr[i] = '0;
      pool_size[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_empty_pool();
    test_best_fit_order();
    test_limit_settings();
    test_random_traffic(5'd16, 200, 50);
    test_random_traffic(5'd31, 200, 65);
    test_random_traffic(5'd3, 150, 50);
    test_random_traffic(5'd1, 150, 50);
    test_random_traffic(5'd0, 100, 40);
    test_random_traffic(5'($urandom_range(2, 15)), 200, 50);
    test_random_traffic(5'($urandom_range(17, 30)), 200, 55);
    calm = 1'b1;
    test_random_traffic(5'd16, 200, 50);
    wait_results_drained();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bfbp_pkg.sv
design/bfbp_cell.sv
design/best_fit_block_pool.sv
bench/tb_best_fit_block_pool.sv
